/* rtl/core/sha256_stream_hasher_macros.svh */
// assertion macros for the sha-256 stream hasher
// no dependencies; included by modules that check their own logic
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define SHA_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define SHA_ASSERT_IMP(lbl, clk, rst, a, c)
`define SHA_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

/* rtl/core/sha_pkg.sv */
// shared types, constants and round functions for the sha-256 hasher
// no dependencies
`timescale 1ns / 1ps
package sha_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_PAD, ST_LEN, ST_OUT
  } state_t;

  typedef struct packed {
    logic absorb;    // write byte at fill position
    logic pad80;     // write 0x80 at fill position
    logic zero_pos;  // write zero at fill position
    logic put_len;   // write length into last 8 bytes
    logic start;     // load working vars from hash
    logic round;     // one compression round
    logic finish;    // add working vars into hash
    logic shift_out; // advance output word
    logic restart;   // back to initial state
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
    logic       out_last;
  } stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction
endpackage

/* rtl/core/sha_datapath.sv */
// sha-256 datapath: block buffer, schedule window, round unit, hash words
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sha_pkg::cmd_t    cmd,
  input  logic [7:0]       data_byte,
  output sha_pkg::stat_t   stat,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index
);
  // block buffer is a 16-word window that becomes the message schedule
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];
  logic [5:0]  fill;
  logic [5:0]  rnd;
  logic [63:0] length_bits;
  logic [2:0]  oidx;
  logic [31:0] t1, t2, w_new;
  logic [63:0] total;
  logic [7:0]  wr_byte;
  logic        wr_en;

  assign total = length_bits + {55'd0, fill, 3'd0};
  assign w_new = sha_pkg::sig1(w[14]) + w[9] + sha_pkg::sig0(w[1]) + w[0];
  assign t1 = v[7] + sha_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
              + sha_pkg::ROUND_K[rnd] + w[0];
  assign t2 = sha_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_comb begin
    wr_en = cmd.absorb | cmd.pad80 | cmd.zero_pos;
    wr_byte = cmd.absorb ? data_byte : (cmd.pad80 ? sha_pkg::PAD_BYTE : 8'd0);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (fill[1:0])
        2'd0: w[fill[5:2]][31:24] <= wr_byte;
        2'd1: w[fill[5:2]][23:16] <= wr_byte;
        2'd2: w[fill[5:2]][15:8] <= wr_byte;
        default: w[fill[5:2]][7:0] <= wr_byte;
      endcase
    end else if (cmd.put_len) begin
      // message length was captured when the 0x80 byte went in
      w[14] <= length_bits[63:32];
      w[15] <= length_bits[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= w_new;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (cmd.round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) h[i] <= sha_pkg::H_INIT[i];
      fill <= '0;
      length_bits <= '0;
      rnd <= '0;
      oidx <= '0;
    end else begin
      if (cmd.absorb) begin
        fill <= fill + 6'd1;
        if (fill == 6'd63) length_bits <= length_bits + 64'd512;
      end else if (cmd.pad80) begin
        length_bits <= total;
        fill <= fill + 6'd1;
      end else if (cmd.zero_pos) begin
        fill <= fill + 6'd1;
      end else if (cmd.put_len) begin
        fill <= '0;
      end
      if (cmd.start) rnd <= '0;
      else if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.finish) begin
        // last round is folded straight into the hash words
        h[0] <= h[0] + t1 + t2;
        h[1] <= h[1] + v[0];
        h[2] <= h[2] + v[1];
        h[3] <= h[3] + v[2];
        h[4] <= h[4] + v[3] + t1;
        h[5] <= h[5] + v[4];
        h[6] <= h[6] + v[5];
        h[7] <= h[7] + v[6];
      end
      if (cmd.shift_out) oidx <= oidx + 3'd1;
    end
  end

  assign stat.fill = fill;
  assign stat.last_round = (rnd == 6'd63);
  assign stat.out_last = (oidx == 3'd7);
  assign digest_word = h[oidx];
  assign word_index = oidx;

  `include "sha256_stream_hasher_macros.svh"
  `SHA_ASSERT_IMP(a_one_write, clk, rst, 1'b1, $onehot0({cmd.absorb, cmd.pad80, cmd.zero_pos, cmd.put_len}))
  `SHA_ASSERT_NEXT(a_round_adv, clk, rst, cmd.round && !cmd.start && rnd != 6'd63, rnd == $past(rnd) + 6'd1)
  `SHA_ASSERT_NEXT(a_restart_clr, clk, rst, cmd.restart, fill == 6'd0 && length_bits == 64'd0)
endmodule

/* rtl/core/sha_ctrl.sv */
// sha-256 sequencer: intake, padding, compression rounds and digest output
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_action,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sha_pkg::stat_t  stat,
  output sha_pkg::cmd_t   cmd
);
  sha_pkg::state_t state, state_next;
  logic fin, fin_next;     // compression belongs to a finish
  logic spill, spill_next; // compression is the first of two pad blocks

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      fin <= 1'b0;
      spill <= 1'b0;
    end else begin
      state <= state_next;
      fin <= fin_next;
      spill <= spill_next;
    end
  end

  always_comb begin
    state_next = state;
    fin_next = fin;
    spill_next = spill;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (in_valid) begin
          fin_next = 1'b0;
          spill_next = 1'b0;
          if (!in_action) begin
            if (stat.fill == 6'd63) state_next = sha_pkg::ST_ROUND;
          end else if (stat.fill == 6'd63) begin
            // 0x80 lands in the last byte, length needs a second block
            state_next = sha_pkg::ST_ROUND;
            spill_next = 1'b1;
          end else begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        if (stat.fill == sha_pkg::LEN_POS && !fin) state_next = sha_pkg::ST_LEN;
        else if (stat.fill == 6'd63) begin
          state_next = sha_pkg::ST_ROUND;
          spill_next = 1'b1;
        end
      end
      sha_pkg::ST_LEN: begin
        state_next = sha_pkg::ST_ROUND;
        fin_next = 1'b1;
      end
      sha_pkg::ST_ROUND: begin
        if (stat.last_round) begin
          if (fin) state_next = sha_pkg::ST_OUT;
          else if (spill) begin
            state_next = sha_pkg::ST_PAD;
            spill_next = 1'b0;
          end else state_next = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_OUT: begin
        if (out_ready && stat.out_last) state_next = sha_pkg::ST_IDLE;
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  // words are taken only in idle; a finish is taken with its 0x80 byte
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_ready = 1'b1;
          cmd.absorb = !in_action;
          cmd.pad80 = in_action;
          cmd.start = (stat.fill == 6'd63);
        end
      end
      sha_pkg::ST_PAD: begin
        if (stat.fill == sha_pkg::LEN_POS && !fin) cmd.put_len = 1'b1;
        else begin
          cmd.zero_pos = 1'b1;
          cmd.start = (stat.fill == 6'd63);
        end
      end
      sha_pkg::ST_LEN: cmd.start = 1'b1;
      sha_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.finish = stat.last_round;
      end
      sha_pkg::ST_OUT: begin
        out_valid = 1'b1;
        cmd.shift_out = out_ready;
        cmd.restart = out_ready && stat.out_last;
      end
      default: ;
    endcase
  end

  `include "sha256_stream_hasher_macros.svh"
  `SHA_ASSERT_IMP(a_out_only, clk, rst, out_valid, state == sha_pkg::ST_OUT)
  `SHA_ASSERT_NEXT(a_len_then_round, clk, rst, state == sha_pkg::ST_LEN, state == sha_pkg::ST_ROUND && fin)
  `SHA_ASSERT_IMP(a_no_write_round, clk, rst, state == sha_pkg::ST_ROUND, !cmd.absorb && !cmd.put_len)
endmodule

/* rtl/core/sha256_stream_hasher.sv */
// SHA-256 over a byte stream, one message byte per input word
// usage: s_axis word carries data_byte in tdata and action in tuser;
// action 0 absorbs, 1 finishes the message
// m_axis gives eight digest words, word 0 first, tlast on word 7
// tdata = {word_index, digest_word}
// an absorb is taken whenever the hasher is idle; the 64th byte of a block
// starts the 64 compression rounds, and no byte is taken while they run
// a finish is taken with its 0x80 byte, then pads one zero per cycle up to
// byte 56, writes the length, loads the round unit and runs 64 rounds;
// if 56 or more bytes were held, the first pad block runs its own 64
// rounds before that
// the eight words then follow one per cycle while m_axis is ready; no input
// is taken until word 7 is delivered and the hasher is back in idle
// stalls on m_axis hold the current word; nothing else moves
// reset (rst, synchronous) loads the initial hash and clears the counters
// depends on sha_pkg, sha_ctrl, sha_datapath
`timescale 1ns / 1ps
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast   // last_word
);
  sha_pkg::cmd_t  cmd;
  sha_pkg::stat_t stat;
  logic [31:0] dw;
  logic [2:0]  wi;

  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_action(s_axis_tuser), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(s_axis_tdata),
    .stat(stat), .digest_word(dw), .word_index(wi)
  );

  assign m_axis_tdata = {5'd0, wi, dw};
  assign m_axis_tlast = stat.out_last;
endmodule
